// File: sv/hcurl_pkg.sv
// shared types, constants and the divisor reciprocal table of the line legendre basis core
package hcurl_pkg;

	localparam int MAX_ORDER = 15;
	localparam int K_W       = 4;
	localparam int VAL_W     = 16;
	localparam int OP_W      = 22;
	localparam int PROD_W    = 2 * OP_W;
	localparam int NUM_W     = 21;
	localparam int RECIP_W   = 21;
	localparam int RECIP_SH  = 22;

	localparam logic signed [VAL_W-1:0] ONE_Q14  = 16'sd16384;
	localparam logic signed [VAL_W-1:0] MONE_Q14 = -16'sd16384;

	localparam logic CFG_ORDER = 1'b0;
	localparam logic CFG_NEG   = 1'b1;

	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// floor(2^22 / (2k)) for the divide by 2k
	function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
		logic [RECIP_W-1:0] r;
		case (k)
			4'd2:    r = 21'd1048576;
			4'd3:    r = 21'd699050;
			4'd4:    r = 21'd524288;
			4'd5:    r = 21'd419430;
			4'd6:    r = 21'd349525;
			4'd7:    r = 21'd299593;
			4'd8:    r = 21'd262144;
			4'd9:    r = 21'd233016;
			4'd10:   r = 21'd209715;
			4'd11:   r = 21'd190650;
			4'd12:   r = 21'd174762;
			4'd13:   r = 21'd161319;
			4'd14:   r = 21'd149796;
			4'd15:   r = 21'd139810;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/hcurl_mul.sv
// shared signed multiplier with a registered product
module hcurl_mul (
	input  logic                 clk,
	input  hcurl_pkg::op_t       op_a,
	input  hcurl_pkg::op_t       op_b,
	output hcurl_pkg::prod_t     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// File: sv/hcurl_line_legendre_basis_core.sv
// top level: legendre recurrence sequencer around one shared multiplier
//
//  channel   | handshake                  | beat
//  ----------+----------------------------+-------------------------------
//  item in   | start, busy                | coordinate
//  results   | result_strobe (no stall)   | index, value, last
//  config    | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// each beat in gives order+1 results; k = 0 and k = 1 take one cycle each,
// every k >= 2 takes seven cycles, five of them using the shared multiplier
// busy lasts order+1 cycles for order <= 1, else 2 + 7*(order-1) cycles
// a new beat may be taken in the cycle the last result is shown
// reset clears the sequencer, the result strobe and both config registers
module hcurl_line_legendre_basis_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [hcurl_pkg::VAL_W-1:0]  coordinate,
	output logic                                result_strobe,
	output logic [hcurl_pkg::K_W-1:0]           index,
	output logic signed [hcurl_pkg::VAL_W-1:0]  value,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [hcurl_pkg::K_W-1:0]           cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SEED = 4'd1;
	localparam logic [3:0] ST_P    = 4'd2;
	localparam logic [3:0] ST_A    = 4'd3;
	localparam logic [3:0] ST_B    = 4'd4;
	localparam logic [3:0] ST_C    = 4'd5;
	localparam logic [3:0] ST_D    = 4'd6;
	localparam logic [3:0] ST_E    = 4'd7;
	localparam logic [3:0] ST_F    = 4'd8;

	logic [3:0]                                state_q;
	logic [hcurl_pkg::K_W-1:0]                 order_q;
	logic                                      neg_orient_q;
	logic [hcurl_pkg::K_W-1:0]                 top_q;
	logic [hcurl_pkg::K_W-1:0]                 k_q;
	logic signed [hcurl_pkg::VAL_W-1:0]        u_q;
	logic signed [hcurl_pkg::VAL_W-1:0]        l1_q;
	logic signed [hcurl_pkg::VAL_W-1:0]        l2_q;
	logic signed [hcurl_pkg::VAL_W-1:0]        pr_q;
	logic signed [hcurl_pkg::OP_W-1:0]         b_q;
	logic [hcurl_pkg::NUM_W-1:0]               nabs_q;
	logic                                      nneg_q;
	logic [hcurl_pkg::NUM_W-1:0]               q0_q;

	hcurl_pkg::op_t                            op_a;
	hcurl_pkg::op_t                            op_b;
	hcurl_pkg::prod_t                          prod_q;

	logic signed [hcurl_pkg::VAL_W-1:0]        u_sat;
	logic [hcurl_pkg::K_W-1:0]                 top_eff;
	logic [4:0]                                div_d;
	logic signed [29:0]                        p_rnd;
	logic signed [hcurl_pkg::OP_W:0]           n_sum;
	logic signed [hcurl_pkg::OP_W:0]           num;
	logic [hcurl_pkg::OP_W-1:0]                r0;
	logic                                      r_ge;
	logic [hcurl_pkg::OP_W-1:0]                r1;
	logic [hcurl_pkg::NUM_W-1:0]               q_mag;
	logic signed [hcurl_pkg::NUM_W:0]          q_sgn;
	logic signed [hcurl_pkg::VAL_W-1:0]        term_val;
	logic signed [hcurl_pkg::VAL_W-1:0]        emit_val;
	logic                                      emit;

	hcurl_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign div_d     = {k_q, 1'b0};

	always_comb begin
		if (coordinate > hcurl_pkg::ONE_Q14) begin
			u_sat = hcurl_pkg::ONE_Q14;
		end else if (coordinate < hcurl_pkg::MONE_Q14) begin
			u_sat = hcurl_pkg::MONE_Q14;
		end else begin
			u_sat = coordinate;
		end
		if ({1'b0, order_q} > 5'(hcurl_pkg::MAX_ORDER)) begin
			top_eff = hcurl_pkg::K_W'(hcurl_pkg::MAX_ORDER);
		end else begin
			top_eff = order_q;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_P: begin
				op_a = hcurl_pkg::OP_W'(u_q);
				op_b = hcurl_pkg::OP_W'(l1_q);
			end
			ST_A: begin
				op_a = hcurl_pkg::op_t'({1'b0, k_q - 4'd1});
				op_b = hcurl_pkg::OP_W'(l2_q);
			end
			ST_B: begin
				op_a = hcurl_pkg::op_t'({div_d - 5'd1});
				op_b = hcurl_pkg::OP_W'(pr_q);
			end
			ST_D: begin
				op_a = hcurl_pkg::op_t'({1'b0, nabs_q});
				op_b = hcurl_pkg::op_t'({1'b0, hcurl_pkg::recip(k_q)});
			end
			ST_E: begin
				op_a = hcurl_pkg::op_t'({1'b0, prod_q[42:22]});
				op_b = hcurl_pkg::op_t'({1'b0, div_d});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		p_rnd   = prod_q[29:0] + 30'sd8192;
		n_sum   = prod_q[hcurl_pkg::OP_W:0] - {b_q[hcurl_pkg::OP_W-1], b_q};
		num     = (n_sum <<< 1) + $signed({19'd0, k_q});
		r0      = {1'b0, nabs_q} - prod_q[hcurl_pkg::OP_W-1:0];
		r_ge    = (r0 >= hcurl_pkg::OP_W'(div_d));
		r1      = r_ge ? (r0 - hcurl_pkg::OP_W'(div_d)) : r0;
		q_mag   = q0_q + hcurl_pkg::NUM_W'(r_ge) + hcurl_pkg::NUM_W'(nneg_q && (r1 != '0));
		q_sgn   = nneg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		if (q_sgn > $signed(22'sd16384)) begin
			term_val = hcurl_pkg::ONE_Q14;
		end else if (q_sgn < -$signed(22'sd16384)) begin
			term_val = hcurl_pkg::MONE_Q14;
		end else begin
			term_val = q_sgn[hcurl_pkg::VAL_W-1:0];
		end
		if (state_q == ST_SEED) begin
			emit_val = (k_q == '0) ? hcurl_pkg::ONE_Q14 : u_q;
		end else begin
			emit_val = term_val;
		end
		emit = (state_q == ST_SEED) || (state_q == ST_F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			order_q       <= '0;
			neg_orient_q  <= 1'b0;
			top_q         <= '0;
			k_q           <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hcurl_pkg::CFG_ORDER: order_q      <= cfg_data;
					hcurl_pkg::CFG_NEG:   neg_orient_q <= cfg_data[0];
					default:              order_q      <= order_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						top_q   <= top_eff;
						k_q     <= '0;
						state_q <= ST_SEED;
					end
				end
				ST_P:    state_q <= ST_A;
				ST_A:    state_q <= ST_B;
				ST_B:    state_q <= ST_C;
				ST_C:    state_q <= ST_D;
				ST_D:    state_q <= ST_E;
				ST_E:    state_q <= ST_F;
				ST_SEED, ST_F: begin
					result_strobe <= 1'b1;
					if (k_q == top_q) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= (k_q == '0) ? ST_SEED : ST_P;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			u_q <= u_sat;
		end
		if (state_q == ST_A) begin
			pr_q <= p_rnd[29:14];
		end
		if (state_q == ST_B) begin
			b_q <= prod_q[hcurl_pkg::OP_W-1:0];
		end
		if (state_q == ST_C) begin
			nneg_q <= num[hcurl_pkg::OP_W];
			nabs_q <= num[hcurl_pkg::OP_W] ? hcurl_pkg::NUM_W'(-num) : hcurl_pkg::NUM_W'(num);
		end
		if (state_q == ST_E) begin
			q0_q <= prod_q[42:22];
		end
		if (emit) begin
			l2_q  <= l1_q;
			l1_q  <= emit_val;
			index <= k_q;
			value <= (neg_orient_q && !k_q[0]) ? -emit_val : emit_val;
			last  <= (k_q == top_q);
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("sequencer went idle before the last result");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (value <= 16'sd16384) && (value >= -16'sd16384))
		else $error("result outside the unit range");

	a_term_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F |-> k_q >= 4'd2)
		else $error("recurrence step entered for a seed order");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (last == (index == $past(top_q))))
		else $error("last flag does not match the top order");

endmodule

// File: bench/testbench.sv
// self-checking bench for the line legendre basis core: predicted terms vs. result beats
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hcurl_pkg::*;

	localparam int UNIT       = 1 << (VAL_W - 2);
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 41;

	typedef struct packed {
		logic [K_W-1:0]          index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} basis_term_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic signed [VAL_W-1:0] coordinate = '0;
	logic                    result_strobe;
	logic [K_W-1:0]          index;
	logic signed [VAL_W-1:0] value;
	logic                    last;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic                    cfg_index = CFG_ORDER;
	logic [K_W-1:0]          cfg_data = '0;

	logic [K_W-1:0] order_reg = '0;
	logic           neg_reg = 1'b0;
	basis_term_t    expected_terms[$];
	int             mismatch_count = 0;
	int             stall_cycles = 0;
	int             burst_left = 0;

	hcurl_line_legendre_basis_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.coordinate    (coordinate),
		.result_strobe (result_strobe),
		.index         (index),
		.value         (value),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint floor_quot(longint n, longint d);
		if (n >= 0) begin
			return n / d;
		end
		return -((-n + d - 1) / d);
	endfunction

	function automatic int clamp_unit(longint v);
		if (v > UNIT) begin
			return UNIT;
		end
		if (v < -UNIT) begin
			return -UNIT;
		end
		return int'(v);
	endfunction

	// three-term recurrence on unnegated values, orientation applied on output only
	function automatic void push_legendre_terms(logic signed [VAL_W-1:0] coord);
		int          u;
		int          top;
		int          lk;
		int          lk1;
		int          lk2;
		int          shown;
		longint      prod;
		longint      prod_r;
		longint      num;
		basis_term_t term;
		u = clamp_unit(longint'(coord));
		top = (int'(order_reg) > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
		lk1 = 0;
		lk2 = 0;
		for (int k = 0; k <= top; k++) begin
			if (k == 0) begin
				lk = UNIT;
			end else if (k == 1) begin
				lk = u;
			end else begin
				prod = longint'(u) * longint'(lk1);
				prod_r = floor_quot(prod + UNIT / 2, UNIT);
				num = longint'(2 * k - 1) * prod_r - longint'(k - 1) * longint'(lk2);
				lk = clamp_unit(floor_quot(2 * num + k, 2 * k));
			end
			lk2 = lk1;
			lk1 = lk;
			shown = (neg_reg && (k % 2 == 0)) ? -lk : lk;
			term.index = K_W'(k);
			term.value = VAL_W'(shown);
			term.last = (k == top);
			expected_terms.push_back(term);
		end
	endfunction

	function automatic logic signed [VAL_W-1:0] random_coordinate();
		case ($urandom_range(0, 9))
			0: return VAL_W'($urandom);
			1: begin
				case ($urandom_range(0, 5))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return MONE_Q14;
					3: return ONE_Q14;
					4: return -16'sd16385;
					default: return 16'sd16385;
				endcase
			end
			default: return VAL_W'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
		endcase
	endfunction

	task automatic send_coordinate(input logic signed [VAL_W-1:0] coord);
		start <= 1'b1;
		coordinate <= coord;
		do @(posedge clk); while (busy);
		push_legendre_terms(coord);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0: burst_left = $urandom_range(20, 60);
				default: burst_left = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 3))
				0: gap = $urandom_range(13, 90);
				default: gap = $urandom_range(1, 12);
			endcase
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_terms.size() != 0 || busy);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [K_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ORDER) begin
			order_reg = data;
		end else begin
			neg_reg = data[0];
		end
	endtask

	task automatic set_config(input logic [K_W-1:0] ord, input logic [K_W-1:0] neg_data);
		if ($urandom_range(0, 1)) begin
			write_register(CFG_ORDER, ord);
			write_register(CFG_NEG, neg_data);
		end else begin
			write_register(CFG_NEG, neg_data);
			write_register(CFG_ORDER, ord);
		end
		cfg_valid <= 1'b0;
	endtask

	// order 0 and positive orientation out of reset
	task automatic test_reset_state();
		send_coordinate(-16'sd32768);
		send_coordinate(16'sd5000);
		drain_results();
	endtask

	task automatic test_coordinate_extremes();
		logic signed [VAL_W-1:0] picks[8] = '{-16'sd32768, 16'sd32767, -16'sd16385,
			16'sd16385, -16'sd16384, 16'sd16384, 16'sd0, -16'sd1};
		set_config(4'd15, 4'd0);
		foreach (picks[i]) begin
			send_coordinate(picks[i]);
		end
		drain_results();
	endtask

	task automatic test_orientation();
		logic signed [VAL_W-1:0] picks[4] = '{16'sd1, 16'sd8192, -16'sd8192, 16'sd11585};
		set_config(4'd15, 4'hf);
		foreach (picks[i]) begin
			send_coordinate(picks[i]);
		end
		drain_results();
	endtask

	task automatic test_low_orders();
		set_config(4'd1, 4'd1);
		send_coordinate(-16'sd1000);
		drain_results();
		set_config(4'd2, 4'd0);
		send_coordinate(16'sd12345);
		drain_results();
	endtask

	task automatic test_random_phases();
		logic [K_W-1:0] ord;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: ord = 4'd0;
				1: ord = 4'd15;
				2: ord = 4'd1;
				default: ord = K_W'($urandom_range(0, 15));
			endcase
			set_config(ord, K_W'($urandom_range(0, 15)));
			burst_left = 0;
			repeat (PHASE_ITEMS) begin
				send_coordinate(random_coordinate());
				pace_sender();
			end
			drain_results();
		end
	endtask

	always @(posedge clk) begin : check_results
		basis_term_t want;
		if (arst_n && result_strobe) begin
			if (expected_terms.size() == 0) begin
				$display("%0t: unexpected beat index %0d value %0d last %0b",
					$time, index, value, last);
				mismatch_count++;
			end else begin
				want = expected_terms.pop_front();
				if (index !== want.index) begin
					$display("%0t: index expected %0d actual %0d", $time, want.index, index);
					mismatch_count++;
				end
				if (value !== want.value) begin
					$display("%0t: value (k=%0d) expected %0d actual %0d",
						$time, want.index, want.value, value);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last (k=%0d) expected %0b actual %0b",
						$time, want.index, want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("hcurl_line_legendre_basis_core verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_coordinate_extremes();
		test_orientation();
		test_low_orders();
		test_random_phases();
		drain_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_terms.size() == 0) begin
			$display("hcurl_line_legendre_basis_core verification clean");
		end else begin
			$display("hcurl_line_legendre_basis_core verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/hcurl_pkg.sv
sv/hcurl_mul.sv
sv/hcurl_line_legendre_basis_core.sv
bench/testbench.sv
